[rtl/core/dma_chunk_descriptor_generator_assert.svh]
// Assertion macros used by the checker file of the descriptor generator.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef DMA_CHUNK_DESCRIPTOR_GENERATOR_ASSERT_SVH
`define DMA_CHUNK_DESCRIPTOR_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCDG_ASSERT_NOW(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCDG_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error(msg);

`endif

[rtl/core/dcdg_pkg.sv]
// Package for the DMA chunk descriptor generator: sizes, control bits, beat types.
// Used by every module of the block; depends on nothing.
package dcdg_pkg;

   localparam int CHUNK_BYTES     = 4095;
   localparam int MAX_DESCRIPTORS = 64;
   localparam int DESC_BYTES      = 16;

   localparam int LEN_W   = 20;
   localparam int ADDR_W  = 32;
   localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);

   // Longest request that still fits in the descriptor list.
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DESCRIPTORS * CHUNK_BYTES);

   localparam logic [ADDR_W-1:0] CTL_TX_BITS = (32'd1 << 25) | (32'd1 << 26);
   localparam logic [ADDR_W-1:0] CTL_RX_BITS = (32'd1 << 24) | (32'd1 << 27);
   localparam logic [ADDR_W-1:0] CTL_IRQ_BIT = 32'd1 << 31;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] source_addr;
      logic [ADDR_W-1:0] dest_addr;
      logic [ADDR_W-1:0] list_base;
      logic              transmit;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] desc_source;
      logic [ADDR_W-1:0] desc_dest;
      logic [ADDR_W-1:0] desc_next;
      logic [ADDR_W-1:0] desc_control;
      logic              last;
      logic              too_long;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request beat
      logic step;    // emit the current descriptor and advance
      logic reject;  // emit the too-long result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // output register can take a descriptor this cycle
      logic req_zero;    // incoming request has zero length
      logic req_long;    // incoming request needs too many descriptors
      logic last_chunk;  // current descriptor is the final one
   } sts_type;

endpackage

[rtl/core/dcdg_ctrl.sv]
// Controller state machine of the DMA chunk descriptor generator.
// Depends on dcdg_pkg; drives the datapath through cmd_type, reads sts_type.
module dcdg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dcdg_pkg::sts_type sts,
   output dcdg_pkg::cmd_type cmd
);
   import dcdg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_GEN    = 3'b010,
      ST_REJECT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!sts.req_zero) begin
                  state_in = sts.req_long ? ST_REJECT : ST_GEN;
               end
            end
         end
         ST_GEN: begin
            if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.last_chunk) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REJECT: begin
            if (sts.out_free) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/dcdg_datapath.sv]
// Datapath of the DMA chunk descriptor generator: chunk walk and output register.
// Depends on dcdg_pkg; steered by the controller through cmd_type.
module dcdg_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dcdg_pkg::req_type req_payload,
   input  dcdg_pkg::cmd_type cmd,
   output dcdg_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcdg_pkg::rsp_type rsp_payload
);
   import dcdg_pkg::*;

   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [ADDR_W-1:0]  src_ff, src_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;
   logic [ADDR_W-1:0]  next_ff, next_in;
   logic               tx_ff, tx_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               is_last;
   logic [CHUNK_W-1:0] size;
   rsp_type            desc;

   assign is_last = (remain_ff <= LEN_W'(CHUNK_BYTES));
   assign size    = is_last ? remain_ff[CHUNK_W-1:0] : CHUNK_W'(CHUNK_BYTES);

   always_comb begin
      desc              = '0;
      desc.desc_source  = src_ff;
      desc.desc_dest    = dst_ff;
      desc.desc_next    = is_last ? '0 : next_ff;
      desc.desc_control = ADDR_W'(size) | (tx_ff ? CTL_TX_BITS : CTL_RX_BITS)
                        | (is_last ? CTL_IRQ_BIT : '0);
      desc.last         = is_last;
      desc.too_long     = 1'b0;
   end

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.req_zero   = (req_payload.length == '0);
   assign sts.req_long   = (req_payload.length > MAX_LEN);
   assign sts.last_chunk = is_last;

   always_comb begin
      remain_in    = remain_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      next_in      = next_ff;
      tx_in        = tx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         remain_in = req_payload.length;
         src_in    = req_payload.source_addr;
         dst_in    = req_payload.dest_addr;
         next_in   = req_payload.list_base + ADDR_W'(DESC_BYTES);
         tx_in     = req_payload.transmit;
      end else if (cmd.step) begin
         rsp_in       = desc;
         rsp_valid_in = 1'b1;
         remain_in    = remain_ff - LEN_W'(CHUNK_BYTES);
         next_in      = next_ff + ADDR_W'(DESC_BYTES);
         if (tx_ff) begin
            src_in = src_ff + ADDR_W'(CHUNK_BYTES);
         end else begin
            dst_in = dst_ff + ADDR_W'(CHUNK_BYTES);
         end
      end else if (cmd.reject) begin
         rsp_in          = '0;
         rsp_in.last     = 1'b1;
         rsp_in.too_long = 1'b1;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      next_ff   <= next_in;
      tx_ff     <= tx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/core/dma_chunk_descriptor_generator.sv]
// Order: the request beat is taken into the work registers, then each step loads the output register.
// Throughput: one descriptor per cycle while the consumer is ready; the controller takes
// no new request until the last descriptor or the flagged beat of a request is stepped out.
// The rate is set by the single chunk-walk step in the datapath, one chunk per cycle while the output register is free.
// Reset: synchronous, active high; clears the controller state and the output valid.
// Depends on dcdg_pkg, dcdg_ctrl and dcdg_datapath.
module dma_chunk_descriptor_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dcdg_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcdg_pkg::rsp_type rsp_payload
);
   import dcdg_pkg::*;

   // The controller takes a request only in its idle state. The request beat is
   // captured into the datapath's work registers (remaining length, both
   // addresses, next list address, direction). Zero-length requests are taken
   // and dropped; requests longer than the list allows produce one flagged beat.
   cmd_type cmd;
   sts_type sts;

   dcdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath walks the request one chunk per step: each step loads the
   // output register with a descriptor, subtracts one chunk from the remaining
   // length and advances the memory-side address and the list pointer. The
   // output register lets the last descriptor wait on the consumer while the
   // controller already takes the next request.
   dcdg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/core/dcdg_checker.sv]
// Port-level checker for the DMA chunk descriptor generator, bound to the top level.
// Depends on dcdg_pkg and the assertion macro header.
`include "dma_chunk_descriptor_generator_assert.svh"

module dcdg_assert_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dcdg_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dcdg_pkg::rsp_type rsp_payload
);
   import dcdg_pkg::*;

   // A waiting request beat must hold until it is taken.
   `DCDG_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_payload), "waiting request beat changed")

   // A stalled descriptor beat must hold.
   `DCDG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled descriptor beat changed")

   // A rejected request yields a single blank beat marked last.
   `DCDG_ASSERT_NOW(a_reject_blank, rsp_valid && rsp_payload.too_long, rsp_payload.last && rsp_payload.desc_next == '0 && rsp_payload.desc_control == '0, "too-long beat not blank")

   // The final descriptor ends the list and raises the interrupt bit.
   `DCDG_ASSERT_NOW(a_last_desc, rsp_valid && rsp_payload.last && !rsp_payload.too_long, rsp_payload.desc_next == '0 && rsp_payload.desc_control[31], "last descriptor malformed")

   // Every descriptor before the last carries a full chunk and no interrupt.
   `DCDG_ASSERT_NOW(a_full_chunk, rsp_valid && !rsp_payload.last, !rsp_payload.too_long && !rsp_payload.desc_control[31] && rsp_payload.desc_control[CHUNK_W-1:0] == CHUNK_W'(CHUNK_BYTES), "inner descriptor not a full chunk")

endmodule

bind dma_chunk_descriptor_generator dcdg_assert_checker u_dcdg_checker (.*);
